[hw/rtl/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and calibration decode for the barometric
// temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int TEMP_STAGES  = 5;
  localparam int PRESS_STAGES = 7;
  localparam int STAGES       = TEMP_STAGES + PRESS_STAGES;
  localparam int SUM_W        = 112;
  localparam int PRESS_SHIFT  = 79;

  localparam logic [1:0] CFG_CALIB_0 = 2'd0;
  localparam logic [1:0] CFG_CALIB_1 = 2'd1;
  localparam logic [1:0] CFG_CALIB_2 = 2'd2;

  localparam logic signed [23:0] TEMP_MIN  = -24'sd2949120;
  localparam logic signed [23:0] TEMP_MAX  = 24'sd5898240;
  localparam logic        [22:0] PRESS_MAX = 23'h7FFFFF;
  localparam logic signed [16:0] P_BIAS    = 17'sd16384;

  typedef logic [167:0] calib_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  function automatic coef_t decode_coef(calib_t c);
    coef_t k;
    k.t1  = c[15:0];
    k.t2  = c[31:16];
    k.t3  = signed'(c[39:32]);
    k.p1  = 17'(signed'(c[55:40])) - P_BIAS;
    k.p2  = 17'(signed'(c[71:56])) - P_BIAS;
    k.p3  = signed'(c[79:72]);
    k.p4  = signed'(c[87:80]);
    k.p5  = c[103:88];
    k.p6  = c[119:104];
    k.p7  = signed'(c[127:120]);
    k.p8  = signed'(c[135:128]);
    k.p9  = signed'(c[151:136]);
    k.p10 = signed'(c[159:152]);
    k.p11 = signed'(c[167:160]);
    return k;
  endfunction

endpackage

[hw/rtl/btpc_ctrl.sv]
// ----------------------------------------------------------------------------
// btpc_ctrl
// Valid bits and per-stage load enables; empty stages fill while the
// output stage is stalled.
// ----------------------------------------------------------------------------
module btpc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [btpc_pkg::STAGES-1:0]  en
);

  localparam int S = btpc_pkg::STAGES;

  logic [S-1:0] v;
  logic [S-1:0] v_next;
  logic [S-1:0] prev;

  always_comb begin
    en[S-1] = !v[S-1] || out_ready;
    for (int i = S - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
    prev = {v[S-2:0], in_valid};
    for (int i = 0; i < S; i++) begin
      v_next[i] = en[i] ? prev[i] : v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[S-1];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result lost under stall");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input blocked with an empty stage");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted transfer not captured");

endmodule

[hw/rtl/btpc_temp.sv]
// ----------------------------------------------------------------------------
// btpc_temp
// Five-stage temperature trim: offset, products, quadratic term, sum,
// truncate toward zero and saturate.
// ----------------------------------------------------------------------------
module btpc_temp (
  input  logic                              clk,
  input  logic [btpc_pkg::TEMP_STAGES-1:0]  en,
  input  btpc_pkg::coef_t                   coef,
  input  logic [23:0]                       raw_pressure,
  input  logic [23:0]                       raw_temperature,
  input  logic [1:0]                        sensor_select,
  output logic signed [23:0]                temp,
  output logic [23:0]                       press_raw,
  output logic [1:0]                        sel
);

  logic signed [24:0] d1;
  logic [23:0]        u1, u2, u3, u4;
  logic [1:0]         s1, s2, s3, s4;
  logic signed [41:0] m2, m3;
  logic [47:0]        sq2;
  logic signed [56:0] q3;
  logic signed [60:0] num4;

  logic signed [24:0] d_next;
  logic signed [41:0] m_next;
  logic signed [49:0] sq_full;
  logic signed [56:0] q_next;
  logic signed [60:0] num_next;
  logic [60:0]        bias;
  logic [60:0]        biased;
  logic signed [28:0] tq;
  logic signed [23:0] temp_next;

  always_comb begin
    d_next   = signed'({1'b0, raw_temperature}) - signed'({1'b0, coef.t1, 8'h00});
    m_next   = 42'(d1) * 42'(signed'({1'b0, coef.t2}));
    sq_full  = 50'(d1) * 50'(d1);
    q_next   = 57'(signed'({1'b0, sq2})) * 57'(coef.t3);
    num_next = (61'(m3) <<< 18) + 61'(q3);
    bias     = num4[60] ? 61'(32'hFFFF_FFFF) : '0;
    biased   = num4 + bias;
    tq       = signed'(biased[60:32]);
    if (tq < 29'(btpc_pkg::TEMP_MIN)) begin
      temp_next = btpc_pkg::TEMP_MIN;
    end else if (tq > 29'(btpc_pkg::TEMP_MAX)) begin
      temp_next = btpc_pkg::TEMP_MAX;
    end else begin
      temp_next = tq[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1 <= d_next;
      u1 <= raw_pressure;
      s1 <= sensor_select;
    end
    if (en[1]) begin
      m2  <= m_next;
      sq2 <= sq_full[47:0];
      u2  <= u1;
      s2  <= s1;
    end
    if (en[2]) begin
      m3 <= m2;
      q3 <= q_next;
      u3 <= u2;
      s3 <= s2;
    end
    if (en[3]) begin
      num4 <= num_next;
      u4   <= u3;
      s4   <= s3;
    end
    if (en[4]) begin
      temp      <= temp_next;
      press_raw <= u4;
      sel       <= s4;
    end
  end

endmodule

[hw/rtl/btpc_press.sv]
// ----------------------------------------------------------------------------
// btpc_press
// Seven-stage pressure polynomial: small products, grouped coefficients,
// split wide products, partial sums, final sum, scale and clamp.
// ----------------------------------------------------------------------------
module btpc_press (
  input  logic                               clk,
  input  logic [btpc_pkg::PRESS_STAGES-1:0]  en,
  input  btpc_pkg::coef_t                    coef,
  input  logic signed [23:0]                 temp,
  input  logic [23:0]                        press_raw,
  input  logic [1:0]                         sel,
  output logic signed [23:0]                 temp_out,
  output logic [22:0]                        press_out,
  output logic [1:0]                         sel_out
);

  localparam int SW            = btpc_pkg::SUM_W;
  localparam int PRESS_SHIFT_W = btpc_pkg::PRESS_SHIFT;

  logic signed [24:0] su;
  logic signed [47:0] tt_full;
  logic [47:0]        uu_full;

  // stage 6
  logic signed [40:0] p6t6, p2t6;
  logic signed [31:0] p7t6, p8t6, p10t6;
  logic [45:0]        tt6;
  logic [47:0]        uu6;
  logic signed [41:0] up1_6;
  logic signed [32:0] up3_6, up4_6, up11_6;
  logic signed [23:0] t6;
  logic [23:0]        u6;
  logic [1:0]         s6;
  // stage 7
  logic signed [55:0] c7;
  logic signed [65:0] f7;
  logic signed [33:0] k07;
  logic signed [56:0] up4t7;
  logic signed [34:0] l7;
  logic signed [40:0] p6t7;
  logic signed [41:0] up1_7;
  logic [45:0]        tt7;
  logic [47:0]        uu7;
  logic signed [23:0] t7;
  logic [1:0]         s7;
  // stage 8
  logic signed [57:0] kk8;
  logic signed [59:0] lul8, luh8;
  logic signed [40:0] p6t8;
  logic signed [55:0] c8;
  logic signed [41:0] up1_8;
  logic signed [65:0] f8;
  logic [45:0]        tt8;
  logic signed [23:0] t8;
  logic [1:0]         s8;
  // stage 9
  logic signed [53:0] pp0, pp1, pp2, pp3;
  logic signed [84:0] lu9;
  logic signed [40:0] p6t9;
  logic signed [55:0] c9;
  logic signed [41:0] up1_9;
  logic signed [65:0] f9;
  logic signed [23:0] t9;
  logic [1:0]         s9;
  // stage 10
  logic signed [SW-1:0] kt10, ra10, rb10;
  logic signed [23:0]   t10;
  logic [1:0]           s10;
  // stage 11
  logic signed [SW-1:0] s11;
  logic signed [23:0]   t11;
  logic [1:0]           s11_sel;

  logic [SW-PRESS_SHIFT_W-1:0] q;
  logic [22:0]                 press_next;

  always_comb begin
    su      = signed'({1'b0, press_raw});
    tt_full = 48'(temp) * 48'(temp);
    uu_full = 48'(press_raw) * 48'(press_raw);
    q       = s11[SW-1:PRESS_SHIFT_W];
    if (s11[SW-1]) begin
      press_next = '0;
    end else if (q > (SW-PRESS_SHIFT_W)'(btpc_pkg::PRESS_MAX)) begin
      press_next = btpc_pkg::PRESS_MAX;
    end else begin
      press_next = q[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p6t6   <= 41'(signed'({1'b0, coef.p6})) * 41'(temp);
      p2t6   <= 41'(coef.p2) * 41'(temp);
      p7t6   <= 32'(coef.p7) * 32'(temp);
      p8t6   <= 32'(coef.p8) * 32'(temp);
      p10t6  <= 32'(coef.p10) * 32'(temp);
      tt6    <= tt_full[45:0];
      uu6    <= uu_full;
      up1_6  <= 42'(su) * 42'(coef.p1);
      up3_6  <= 33'(su) * 33'(coef.p3);
      up4_6  <= 33'(su) * 33'(coef.p4);
      up11_6 <= 33'(su) * 33'(coef.p11);
      t6     <= temp;
      u6     <= press_raw;
      s6     <= sel;
    end
    if (en[1]) begin
      c7    <= 56'(p7t6) * 56'(t6);
      f7    <= 66'(p2t6) * 66'(signed'({1'b0, u6}));
      k07   <= (34'(p8t6) <<< 1) + 34'(up3_6);
      up4t7 <= 57'(up4_6) * 57'(t6);
      l7    <= (35'(coef.p9) <<< 17) + (35'(p10t6) <<< 1) + 35'(up11_6);
      p6t7  <= p6t6;
      up1_7 <= up1_6;
      tt7   <= tt6;
      uu7   <= uu6;
      t7    <= t6;
      s7    <= s6;
    end
    if (en[2]) begin
      kk8   <= (58'(k07) <<< 21) + 58'(up4t7);
      lul8  <= 60'(l7) * 60'(signed'({1'b0, uu7[23:0]}));
      luh8  <= 60'(l7) * 60'(signed'({1'b0, uu7[47:24]}));
      p6t8  <= p6t7;
      c8    <= c7;
      up1_8 <= up1_7;
      f8    <= f7;
      tt8   <= tt7;
      t8    <= t7;
      s8    <= s7;
    end
    if (en[3]) begin
      pp0   <= 54'(signed'({1'b0, kk8[28:0]})) * 54'(signed'({1'b0, tt8[22:0]}));
      pp1   <= 54'(signed'({1'b0, kk8[28:0]})) * 54'(signed'({1'b0, tt8[45:23]}));
      pp2   <= 54'(signed'(kk8[57:29])) * 54'(signed'({1'b0, tt8[22:0]}));
      pp3   <= 54'(signed'(kk8[57:29])) * 54'(signed'({1'b0, tt8[45:23]}));
      lu9   <= (85'(luh8) <<< 24) + 85'(lul8);
      p6t9  <= p6t8;
      c9    <= c8;
      up1_9 <= up1_8;
      f9    <= f8;
      t9    <= t8;
      s9    <= s8;
    end
    if (en[4]) begin
      kt10 <= SW'(pp0) + (SW'(pp1) <<< 23) + (SW'(pp2) <<< 29) + (SW'(pp3) <<< 52);
      ra10 <= (SW'({1'b0, coef.p5}) <<< 88) + (SW'(p6t9) <<< 63) + (SW'(c9) <<< 45);
      rb10 <= (SW'(up1_9) <<< 65) + (SW'(f9) <<< 40) + (SW'(lu9) <<< 20);
      t10  <= t9;
      s10  <= s9;
    end
    if (en[5]) begin
      s11     <= kt10 + ra10 + rb10;
      t11     <= t10;
      s11_sel <= s10;
    end
    if (en[6]) begin
      press_out <= press_next;
      temp_out  <= t11;
      sel_out   <= s11_sel;
    end
  end

endmodule

[hw/rtl/baro_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Trim compensation of raw barometer readings: quadratic temperature and
// cubic pressure polynomial in exact fixed point.
//
//   channel | signals                                           | transfer
//   --------+---------------------------------------------------+----------------------
//   in      | raw_pressure, raw_temperature, sensor_select      | in_valid & in_ready
//   out     | temperature_out, pressure_out, temp_valid,        | out_valid & out_ready
//           | press_valid                                       |
//   cfg     | cfg_index, cfg_data                               | cfg_we
//
// Twelve register stages: five for temperature, seven for pressure.
// One transfer per cycle unless a stalled output has filled every stage.
// Reset clears the valid bits and the calibration words.
// A stalled output holds; empty stages behind it keep filling.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  input  logic [1:0]         sensor_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] temperature_out,
  output logic [22:0]        pressure_out,
  output logic               temp_valid,
  output logic               press_valid,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] calib0;
  logic [63:0] calib1;
  logic [39:0] calib2;

  btpc_pkg::coef_t                  coef;
  logic [btpc_pkg::STAGES-1:0]      en;
  logic signed [23:0]               t_mid;
  logic [23:0]                      u_mid;
  logic [1:0]                       sel_mid;
  logic signed [23:0]               t_end;
  logic [22:0]                      p_end;
  logic [1:0]                       sel_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib0 <= '0;
      calib1 <= '0;
      calib2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::CFG_CALIB_0: calib0 <= cfg_data;
        btpc_pkg::CFG_CALIB_1: calib1 <= cfg_data;
        btpc_pkg::CFG_CALIB_2: calib2 <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign coef = btpc_pkg::decode_coef({calib2, calib1, calib0});

  btpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  btpc_temp u_temp (
    .clk             (clk),
    .en              (en[btpc_pkg::TEMP_STAGES-1:0]),
    .coef            (coef),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .sensor_select   (sensor_select),
    .temp            (t_mid),
    .press_raw       (u_mid),
    .sel             (sel_mid)
  );

  btpc_press u_press (
    .clk       (clk),
    .en        (en[btpc_pkg::STAGES-1:btpc_pkg::TEMP_STAGES]),
    .coef      (coef),
    .temp      (t_mid),
    .press_raw (u_mid),
    .sel       (sel_mid),
    .temp_out  (t_end),
    .press_out (p_end),
    .sel_out   (sel_end)
  );

  assign temp_valid      = |sel_end;
  assign press_valid     = sel_end[0];
  assign temperature_out = temp_valid ? t_end : '0;
  assign pressure_out    = press_valid ? p_end : '0;

  a_press_implies_temp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && press_valid) |-> temp_valid)
    else $error("pressure without temperature");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !temp_valid) |-> (temperature_out == '0 && pressure_out == '0))
    else $error("unselected result not cleared");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && temp_valid) |->
      (temperature_out >= btpc_pkg::TEMP_MIN && temperature_out <= btpc_pkg::TEMP_MAX))
    else $error("temperature outside clamp");

endmodule
